// ===== rtl/core/kti_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kti_pkg
// Shared types and constants of the keyframe track interpolator.
// ----------------------------------------------------------------------------
package kti_pkg;

	localparam int MAX_KEYS = 64;
	localparam int AW       = $clog2(MAX_KEYS);
	localparam int CW       = $clog2(MAX_KEYS + 1);

	localparam logic [2:0] CMD_QUERY  = 3'd0;
	localparam logic [2:0] CMD_INSERT = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_CHECK  = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic signed [31:0] Q_ONE = 32'sd65536;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD_PREV,   // read t[idx-1]
		S_RD_NEXT,   // read t[idx] / t[idx+1]
		S_WT_NEXT,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WRITE,
		S_Q_FIRST,
		S_Q_FIRST_W,
		S_Q_SCAN,
		S_Q_SCAN_W,
		S_Q_PAIR,
		S_Q_PAIR_W,
		S_Q_MUL,
		S_Q_DGO,
		S_Q_DIV,
		S_Q_FIN,
		S_TAIL,
		S_TAIL_W,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic          load;      // capture the command
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          cap_a;     // store read time/offset in a slot
		logic          cap_b;
		logic          b_to_a;    // advance the segment: slot b into slot a
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic          wr_new;    // write new key, else shifted data
		logic          cap_shift;
		logic          mul_go;
		logic          div_go;
		logic          div_step;
		logic          fin;
		logic          cap_tail;
		logic          set_count;
		logic [CW-1:0] new_count;
		logic          set_status;
		logic [1:0]    status;
		logic          val_first; // result = offset in slot a
		logic          val_last;  // result = offset in slot b
		logic          val_time;  // result = chosen time
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       ordered;   // order rule holds on captured prev/next
		logic       le_first;  // query time <= slot a time
		logic       ge_b;      // query time >= slot b time
		logic       div_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/kti_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kti_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module kti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/kti_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kti_datapath
// Key stores, comparison slots, multiplier and restoring divider.
// ----------------------------------------------------------------------------
module kti_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire kti_pkg::dp_cmd_t  ctl,
	input  wire logic [31:0]     in_time,
	input  wire logic [31:0]     in_offset,
	input  wire logic            has_prev,
	input  wire logic            has_next,
	input  wire logic            first,
	input  wire logic            auto_ok,
	output kti_pkg::dp_stat_t    stat,
	output logic signed [31:0]   value,
	output logic signed [31:0]   tail
);
	import kti_pkg::*;

	logic signed [31:0] t_q, off_q, ta_q, oa_q, tb_q, ob_q, nt;
	logic [31:0] rt, ro, sh_t_q, sh_o_q;
	logic [63:0] prod_q, rem_q;
	logic [31:0] span_q, quo_q;
	logic        neg_q;
	logic [5:0]  dcnt_q;
	logic signed [32:0] sum, inc;
	logic signed [63:0] dt, dof, mag;
	logic [64:0] trial;

	kti_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
		.clk, .we(ctl.wr_en), .waddr(ctl.wr_addr),
		.wdata(ctl.wr_new ? nt : sh_t_q),
		.re(ctl.rd_en), .raddr(ctl.rd_addr), .rdata(rt));
	kti_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_offs (
		.clk, .we(ctl.wr_en), .waddr(ctl.wr_addr),
		.wdata(ctl.wr_new ? off_q : sh_o_q),
		.re(ctl.rd_en), .raddr(ctl.rd_addr), .rdata(ro));

	// automatic time on insert only: midpoint when next is positive,
	// else prev + 1.0 saturated
	always_comb begin
		sum = 33'(ta_q) + 33'(tb_q);
		inc = 33'(ta_q) + 33'(Q_ONE);
		if (!(auto_ok && t_q[31])) nt = t_q;
		else if (has_next && tb_q > 0) nt = sum[32:1];
		else if (inc > 33'sh0_7FFF_FFFF) nt = 32'sh7FFF_FFFF;
		else nt = inc[31:0];
	end

	// ta_q holds prev (0 when absent), tb_q holds next
	always_comb begin
		stat.ordered = (nt > ta_q || (first && nt == 0)) && (!has_next || nt < tb_q);
		stat.le_first = t_q <= ta_q;
		stat.ge_b     = t_q >= tb_q;
		stat.div_done = dcnt_q == 6'd0;
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			t_q   <= in_time;
			off_q <= in_offset;
			ta_q  <= '0;
		end
		if (ctl.cap_a) begin
			ta_q <= has_prev ? rt : 32'sd0;
			oa_q <= ro;
		end
		if (ctl.b_to_a) begin
			ta_q <= tb_q;
			oa_q <= ob_q;
		end
		if (ctl.cap_b) begin
			tb_q <= rt;
			ob_q <= ro;
		end
		if (ctl.cap_shift) begin
			sh_t_q <= rt;
			sh_o_q <= ro;
		end
		if (ctl.cap_tail) tail <= rt;
		if (ctl.mul_go) begin
			neg_q  <= dof < 0;
			span_q <= 32'(tb_q - ta_q);
		end
		if (ctl.fin) begin
			if (span_q == 0) value <= oa_q;
			else value <= neg_q ? oa_q - quo_q : oa_q + quo_q;
		end else if (ctl.val_first) value <= oa_q;
		else if (ctl.val_last) value <= ob_q;
		else if (ctl.val_time) value <= nt;
		else if (ctl.load) value <= '0;
	end

	assign dt  = 64'(t_q) - 64'(ta_q);
	assign dof = 64'(ob_q) - 64'(oa_q);
	assign mag = dof < 0 ? -dof : dof;

	// restoring divide, one quotient bit per cycle (quotient fits 32 bits)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (ctl.div_go) dcnt_q <= 6'd32;
		else if (ctl.div_step && dcnt_q != 0) dcnt_q <= dcnt_q - 6'd1;
	end

	assign trial = {rem_q[63:0], prod_q[63]} - {33'd0, span_q};
	always_ff @(posedge clk) begin
		if (ctl.mul_go) begin
			prod_q <= 64'(mag[31:0] * dt[31:0]);
		end else if (ctl.div_go) begin
			// quotient < 2^32 since dt < span, so the top 32 bits never divide
			rem_q  <= {32'd0, prod_q[63:32]};
			prod_q <= {prod_q[31:0], 32'd0};
			quo_q  <= '0;
		end else if (ctl.div_step && dcnt_q != 0) begin
			if (!trial[64]) rem_q <= trial[63:0];
			else rem_q <= {rem_q[62:0], prod_q[63]};
			prod_q <= {prod_q[62:0], 1'b0};
			quo_q  <= {quo_q[30:0], !trial[64]};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/kti_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kti_ctrl
// Command sequencer of the keyframe track interpolator.
// ----------------------------------------------------------------------------
module kti_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2:0]            cmd,
	input  wire logic [6:0]            entry_index,
	input  wire kti_pkg::dp_stat_t     stat,
	output kti_pkg::dp_cmd_t           ctl,
	output logic                       busy,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [kti_pkg::CW-1:0]     count,
	output logic                       has_prev,
	output logic                       has_next,
	output logic                       first,
	output logic                       auto_ok
);
	import kti_pkg::*;

	state_t state_q, state_d;
	logic [2:0]    cmd_q;
	logic [6:0]    idx_q;
	logic [CW-1:0] cnt_q, ptr_q, ptr_d;
	logic [1:0]    st_q;

	assign count    = cnt_q;
	assign status   = st_q;
	assign busy     = state_q != S_IDLE;
	assign first    = idx_q == 7'd0;
	// a query always loads t[0] into slot a, whatever its index field holds
	assign has_prev = (cmd_q == CMD_QUERY) || (idx_q != 7'd0);
	// insert: next is t[idx] if idx < n; check: t[idx+1] if idx+1 < n
	assign has_next = (cmd_q == CMD_INSERT) ? (CW'(idx_q) < cnt_q)
	                                         : (CW'(idx_q) + CW'(1) < cnt_q);
	// only an insert may pick its own time
	assign auto_ok  = cmd_q == CMD_INSERT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			st_q    <= ST_OK;
			cmd_q   <= CMD_QUERY;
			idx_q   <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			if (ctl.load) begin
				cmd_q <= cmd;
				idx_q <= entry_index;
				st_q  <= ST_OK;
			end
			if (ctl.set_status) st_q <= ctl.status;
			if (ctl.set_count) cnt_q <= ctl.new_count;
		end
	end

	always_comb begin
		state_d = state_q;
		ptr_d   = ptr_q;
		ctl     = '0;
		done    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					unique case (cmd) inside
						CMD_QUERY:  state_d = S_Q_FIRST;
						CMD_INSERT, CMD_CHECK: state_d = S_RD_PREV;
						CMD_DELETE: begin
							state_d = S_RD_PREV;
						end
						CMD_CLEAR: begin
							ctl.set_count = 1'b1;
							ctl.new_count = '0;
							state_d = S_TAIL;
						end
						default: state_d = S_TAIL;
					endcase
				end
			end
			S_RD_PREV: begin
				if (cmd_q == CMD_INSERT ? CW'(idx_q) > cnt_q : CW'(idx_q) >= cnt_q) begin
					ctl.set_status = 1'b1;
					ctl.status = ST_RANGE;
					state_d = S_TAIL;
				end else if (cmd_q == CMD_INSERT && cnt_q >= CW'(MAX_KEYS)) begin
					ctl.set_status = 1'b1;
					ctl.status = ST_FULL;
					state_d = S_TAIL;
				end else if (cmd_q == CMD_DELETE) begin
					ptr_d = CW'(idx_q);
					state_d = S_SHIFT_RD;
				end else begin
					ctl.rd_en = 1'b1;
					ctl.rd_addr = AW'(idx_q - 7'd1);
					state_d = S_RD_NEXT;
				end
			end
			S_RD_NEXT: begin
				ctl.cap_a = 1'b1;
				ctl.rd_en = 1'b1;
				ctl.rd_addr = (cmd_q == CMD_INSERT) ? AW'(idx_q) : AW'(idx_q + 7'd1);
				state_d = S_WT_NEXT;
			end
			S_WT_NEXT: begin
				ctl.cap_b = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!stat.ordered) begin
					ctl.set_status = 1'b1;
					ctl.status = ST_ORDER;
					state_d = S_TAIL;
				end else if (cmd_q == CMD_CHECK) begin
					state_d = S_TAIL;
				end else begin
					ctl.val_time = 1'b1;
					ptr_d = cnt_q;
					state_d = S_SHIFT_RD;
				end
			end
			// insert walks ptr down from n to idx+1; delete walks up to n-2
			S_SHIFT_RD: begin
				if (cmd_q == CMD_INSERT) begin
					if (ptr_q > CW'(idx_q)) begin
						ctl.rd_en = 1'b1;
						ctl.rd_addr = AW'(ptr_q - CW'(1));
						state_d = S_SHIFT_WR;
					end else state_d = S_WRITE;
				end else begin
					if (ptr_q + CW'(1) < cnt_q) begin
						ctl.rd_en = 1'b1;
						ctl.rd_addr = AW'(ptr_q + CW'(1));
						state_d = S_SHIFT_WR;
					end else begin
						ctl.set_count = 1'b1;
						ctl.new_count = cnt_q - CW'(1);
						state_d = S_TAIL;
					end
				end
			end
			S_SHIFT_WR: begin
				ctl.cap_shift = 1'b1;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (cmd_q == CMD_INSERT && ptr_q == CW'(idx_q)) begin
					ctl.wr_en = 1'b1;
					ctl.wr_new = 1'b1;
					ctl.wr_addr = AW'(idx_q);
					ctl.set_count = 1'b1;
					ctl.new_count = cnt_q + CW'(1);
					state_d = S_TAIL;
				end else begin
					ctl.wr_en = 1'b1;
					ctl.wr_addr = AW'(ptr_q);
					ptr_d = (cmd_q == CMD_INSERT) ? ptr_q - CW'(1) : ptr_q + CW'(1);
					state_d = S_SHIFT_RD;
				end
			end
			S_Q_FIRST: begin
				if (cnt_q == '0) state_d = S_TAIL;
				else begin
					ctl.rd_en = 1'b1;
					ctl.rd_addr = '0;
					state_d = S_Q_FIRST_W;
				end
			end
			S_Q_FIRST_W: begin
				ctl.cap_a = 1'b1;
				ctl.rd_en = 1'b1;
				ctl.rd_addr = AW'(cnt_q - CW'(1));
				state_d = S_Q_SCAN;
			end
			S_Q_SCAN: begin
				ctl.cap_b = 1'b1;
				state_d = S_Q_SCAN_W;
			end
			S_Q_SCAN_W: begin
				if (stat.le_first) begin
					ctl.val_first = 1'b1;
					state_d = S_TAIL;
				end else if (stat.ge_b) begin
					ctl.val_last = 1'b1;
					state_d = S_TAIL;
				end else begin
					ptr_d = CW'(1);
					ctl.rd_en = 1'b1;
					ctl.rd_addr = AW'(1);
					state_d = S_Q_PAIR;
				end
			end
			// slot a holds t[ptr-1]; read t[ptr] into b until time < t[ptr]
			S_Q_PAIR: begin
				ctl.cap_b = 1'b1;
				state_d = S_Q_PAIR_W;
			end
			S_Q_PAIR_W: begin
				if (!stat.ge_b) begin
					state_d = S_Q_MUL;
				end else begin
					// on equality with t[ptr] the next segment starts there, same result
					ctl.b_to_a = 1'b1;
					ctl.rd_en = 1'b1;
					ctl.rd_addr = AW'(ptr_q + CW'(1));
					ptr_d = ptr_q + CW'(1);
					state_d = S_Q_PAIR;
				end
			end
			S_Q_MUL: begin
				ctl.mul_go = 1'b1;
				state_d = S_Q_DGO;
			end
			S_Q_DGO: begin
				ctl.div_go = 1'b1;
				state_d = S_Q_DIV;
			end
			S_Q_DIV: begin
				if (stat.div_done) state_d = S_Q_FIN;
				else ctl.div_step = 1'b1;
			end
			S_Q_FIN: begin
				ctl.fin = 1'b1;
				state_d = S_TAIL;
			end
			S_TAIL: begin
				if (cnt_q != '0) begin
					ctl.rd_en = 1'b1;
					ctl.rd_addr = AW'(cnt_q - CW'(1));
				end
				state_d = S_TAIL_W;
			end
			S_TAIL_W: begin
				ctl.cap_tail = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				done = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/keyframe_track_interpolator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_core
// Time-sorted keyframe table with linear interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low; its single result is
// shown for one cycle with done high and cannot be held off. A query scans
// the table one entry at a time through the single read port and then runs
// a 32-step divider; insert and delete move the entries behind the index
// one at a time.
module keyframe_track_interpolator_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         cmd,
	input  wire logic [6:0]         entry_index,
	input  wire logic signed [31:0] key_time,
	input  wire logic signed [31:0] key_offset,
	output logic                    done,
	output logic signed [31:0]      result_value,
	output logic [1:0]              status,
	output logic [6:0]              entry_count,
	output logic signed [31:0]      track_length
);
	import kti_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;
	logic [CW-1:0] cnt;
	logic hp, hn, fs, ao;
	logic signed [31:0] tail;

	kti_ctrl u_ctrl (.clk, .arst_n, .start, .cmd, .entry_index, .stat, .ctl,
		.busy, .done, .status, .count(cnt), .has_prev(hp), .has_next(hn),
		.first(fs), .auto_ok(ao));

	kti_datapath u_dp (.clk, .arst_n, .ctl, .in_time(key_time),
		.in_offset(key_offset), .has_prev(hp), .has_next(hn), .first(fs),
		.auto_ok(ao), .stat, .value(result_value), .tail);

	assign entry_count  = 7'(cnt);
	assign track_length = (cnt == '0) ? 32'sd0 : tail;

	// hold the count within the table size
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt <= CW'(MAX_KEYS))
		else $error("count beyond table");
	// busy drops right after each result
	a_done: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy after result");
endmodule
`default_nettype wire

// ===== sim/tb_keyframe_track_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// tb_keyframe_track_interpolator_core
// Self-checking bench for the keyframe table and its linear interpolation.
// ----------------------------------------------------------------------------
// A directed table covers the empty table, the extremes of time and offset,
// the automatic time rules, ordering failures, range errors and the unused
// codes. Random traffic follows, mostly well-formed edits and queries against
// the live table, with bursts that fill it to capacity and some pure noise.
// Every result is checked field by field against its directed row or a predictor held here.
// ----------------------------------------------------------------------------
module tb_keyframe_track_interpolator_core;
	import kti_pkg::*;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         st;
		logic [6:0]         cnt;
		logic signed [31:0] len;
	} key_result_t;

	typedef struct {
		logic [2:0]         c;
		logic [6:0]         idx;
		logic signed [31:0] t;
		logic signed [31:0] o;
		bit                 typed;
		key_result_t        res;
	} table_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         cmd = '0;
	logic [6:0]         entry_index = '0;
	logic signed [31:0] key_time = '0;
	logic signed [31:0] key_offset = '0;
	logic               busy, done;
	logic signed [31:0] result_value, track_length;
	logic [1:0]         status;
	logic [6:0]         entry_count;

	// predictor copy of the table
	logic signed [31:0] model_time [MAX_KEYS];
	logic signed [31:0] model_off  [MAX_KEYS];
	int                 model_n = 0;

	// expected results in flight, as a ring
	key_result_t        exp_ring [64];
	int                 exp_wr = 0;
	int                 exp_rd = 0;
	table_row_t         rows [32];
	int                 n_rows = 0;
	int                 mismatches = 0;

	keyframe_track_interpolator_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.entry_index(entry_index), .key_time(key_time), .key_offset(key_offset),
		.done(done), .result_value(result_value), .status(status),
		.entry_count(entry_count), .track_length(track_length)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ordering rule shared by insert and time check
	function automatic bit time_fits(longint t, longint prev, bit has_next, longint nxt,
			bit first);
		return (t > prev || (first && t == 0)) && (!has_next || t < nxt);
	endfunction

	function automatic logic signed [31:0] interpolate(longint t);
		longint o0, o1, doff, t0, t1;
		longint unsigned mag, q;
		if (model_n == 0) return 0;
		if (t <= model_time[0]) return model_off[0];
		if (t >= model_time[model_n-1]) return model_off[model_n-1];
		for (int i = 0; i + 1 < model_n; i++) begin
			t0 = model_time[i];
			t1 = model_time[i+1];
			if (t >= t0 && t <= t1) begin
				o0 = model_off[i];
				o1 = model_off[i+1];
				if (t1 == t0) return o0;
				doff = o1 - o0;
				mag = doff < 0 ? -doff : doff;
				q = (mag * longint'(t - t0)) / longint'(t1 - t0);
				return doff < 0 ? o0 - longint'(q) : o0 + longint'(q);
			end
		end
		return 0;
	endfunction

	// advance the table by one command and give the result it should produce
	function automatic key_result_t apply_command(logic [2:0] c, logic [6:0] idx,
			logic signed [31:0] t, logic signed [31:0] o);
		key_result_t r;
		longint prev, nxt, nt;
		bit has_next;
		int ix;
		ix = idx;
		r.value = 0;
		r.st = ST_OK;
		case (c)
			CMD_QUERY: r.value = interpolate(t);
			CMD_INSERT: begin
				if (ix > model_n) r.st = ST_RANGE;
				else if (model_n >= MAX_KEYS) r.st = ST_FULL;
				else begin
					prev = ix > 0 ? model_time[ix-1] : 0;
					has_next = ix < model_n;
					nxt = has_next ? model_time[ix] : 0;
					nt = t;
					if (nt < 0) begin
						if (has_next && nxt > 0) nt = (prev + nxt) >>> 1;
						else nt = prev + Q_ONE;
						if (nt > 64'sh7FFF_FFFF) nt = 64'sh7FFF_FFFF;
					end
					if (time_fits(nt, prev, has_next, nxt, ix == 0)) begin
						for (int i = model_n; i > ix; i--) begin
							model_time[i] = model_time[i-1];
							model_off[i] = model_off[i-1];
						end
						model_time[ix] = nt[31:0];
						model_off[ix] = o;
						model_n++;
						r.value = nt[31:0];
					end else r.st = ST_ORDER;
				end
			end
			CMD_DELETE: begin
				if (ix >= model_n) r.st = ST_RANGE;
				else begin
					for (int i = ix; i + 1 < model_n; i++) begin
						model_time[i] = model_time[i+1];
						model_off[i] = model_off[i+1];
					end
					model_n--;
				end
			end
			CMD_CHECK: begin
				if (ix >= model_n) r.st = ST_RANGE;
				else begin
					prev = ix > 0 ? model_time[ix-1] : 0;
					has_next = ix + 1 < model_n;
					nxt = has_next ? model_time[ix+1] : 0;
					if (!time_fits(t, prev, has_next, nxt, ix == 0)) r.st = ST_ORDER;
				end
			end
			CMD_CLEAR: model_n = 0;
			default: ;
		endcase
		r.cnt = 7'(model_n);
		r.len = model_n ? model_time[model_n-1] : 0;
		return r;
	endfunction

	function automatic key_result_t mk(logic signed [31:0] v, logic [1:0] s, int n,
			logic signed [31:0] l);
		key_result_t r;
		r.value = v; r.st = s; r.cnt = 7'(n); r.len = l;
		return r;
	endfunction

	function automatic void add_row(logic [2:0] c, logic [6:0] idx, logic signed [31:0] t,
			logic signed [31:0] o, bit typed, key_result_t r);
		table_row_t row;
		row.c = c; row.idx = idx; row.t = t; row.o = o; row.typed = typed; row.res = r;
		rows[n_rows] = row;
		n_rows++;
	endfunction

	// gap before the next transfer: mostly none, sometimes short, rarely long
	task automatic idle_gap();
		int r, n;
		r = $urandom_range(99);
		n = r < 65 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(20, 60));
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// hold the command until the block takes it, then predict its result
	task automatic send(logic [2:0] c, logic [6:0] idx, logic signed [31:0] t,
			logic signed [31:0] o, bit typed, key_result_t typed_res);
		key_result_t r;
		cmd <= c; entry_index <= idx; key_time <= t; key_offset <= o;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		r = apply_command(c, idx, t, o);
		exp_ring[exp_wr % 64] = typed ? typed_res : r;
		exp_wr++;
		@(negedge clk);
		idle_gap();
	endtask

	function automatic logic signed [31:0] pick_time();
		longint lo, hi;
		int r;
		r = $urandom_range(99);
		if (model_n == 0 || r < 20) return $urandom;
		if (r < 40) return model_time[$urandom_range(0, model_n - 1)];
		lo = model_time[0];
		hi = model_time[model_n-1];
		return 32'(lo + longint'({$urandom, $urandom} % longint'(hi - lo + 1)));
	endfunction

	// random time inside the gap an entry at ix may occupy, or noise
	function automatic logic signed [31:0] gap_time(int ix, int next_ix);
		longint prev, nxt;
		prev = ix > 0 ? model_time[ix-1] : 0;
		nxt = next_ix < model_n ? model_time[next_ix] : 64'sh8000_0000;
		if ($urandom_range(9) < 2 || nxt - prev < 2) return $urandom & 32'h7FFF_FFFF;
		return 32'(prev + 1 + longint'({$urandom, $urandom} % longint'(nxt - prev - 1)));
	endfunction

	// sample the result strobe and compare with the oldest expectation
	always @(posedge clk) begin
		key_result_t e;
		if (done) begin
			if (exp_rd == exp_wr) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result value=%h", result_value);
			end else begin
				e = exp_ring[exp_rd % 64];
				exp_rd++;
				if (e.value !== result_value || e.st !== status || e.cnt !== entry_count
						|| e.len !== track_length) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp v=%h s=%0d n=%0d l=%h got v=%h s=%0d n=%0d l=%h",
							e.value, e.st, e.cnt, e.len, result_value, status,
							entry_count, track_length);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		key_result_t none;
		int r, ix, k;
		logic [2:0] c;
		none = '0;

		// empty table, extremes, automatic time, ordering and range errors, unused codes
		add_row(CMD_QUERY, 0, 5, 0, 1, mk(0, ST_OK, 0, 0));
		add_row(CMD_DELETE, 0, 0, 0, 1, mk(0, ST_RANGE, 0, 0));
		add_row(CMD_CHECK, 0, 0, 0, 1, mk(0, ST_RANGE, 0, 0));
		add_row(CMD_INSERT, 1, 0, 0, 1, mk(0, ST_RANGE, 0, 0));
		add_row(CMD_INSERT, 0, 32'sh8000_0000, 5, 1, mk(Q_ONE, ST_OK, 1, Q_ONE));
		add_row(CMD_INSERT, 0, 0, 32'sh7FFF_FFFF, 1, mk(0, ST_OK, 2, Q_ONE));
		add_row(CMD_INSERT, 1, -1, 7, 1, mk(32768, ST_OK, 3, Q_ONE));
		add_row(CMD_INSERT, 3, 32'sh7FFF_FFFF, 32'sh8000_0000, 1,
			mk(32'sh7FFF_FFFF, ST_OK, 4, 32'sh7FFF_FFFF));
		add_row(CMD_INSERT, 4, -1, 0, 1, mk(0, ST_ORDER, 4, 32'sh7FFF_FFFF));
		add_row(CMD_INSERT, 2, 32768, 0, 1, mk(0, ST_ORDER, 4, 32'sh7FFF_FFFF));
		add_row(CMD_QUERY, 0, 32'sh8000_0000, 0, 1,
			mk(32'sh7FFF_FFFF, ST_OK, 4, 32'sh7FFF_FFFF));
		add_row(CMD_QUERY, 0, 32'sh7FFF_FFFF, 0, 1,
			mk(32'sh8000_0000, ST_OK, 4, 32'sh7FFF_FFFF));
		add_row(CMD_QUERY, 0, 100000, 0, 0, none);
		add_row(CMD_QUERY, 0, 40000, 0, 0, none);
		add_row(CMD_QUERY, 0, 32'sh4000_0000, 0, 0, none);
		add_row(CMD_CHECK, 0, 0, 0, 1, mk(0, ST_OK, 4, 32'sh7FFF_FFFF));
		add_row(CMD_CHECK, 1, 0, 0, 1, mk(0, ST_ORDER, 4, 32'sh7FFF_FFFF));
		add_row(CMD_CHECK, 4, 0, 0, 1, mk(0, ST_RANGE, 4, 32'sh7FFF_FFFF));
		add_row(CMD_CHECK, 3, 32'sh7FFF_FFFF, 0, 1, mk(0, ST_OK, 4, 32'sh7FFF_FFFF));
		add_row(3'd5, 0, -1, -1, 1, mk(0, ST_OK, 4, 32'sh7FFF_FFFF));
		add_row(3'd7, 7'd127, 32'sh7FFF_FFFF, 1, 1, mk(0, ST_OK, 4, 32'sh7FFF_FFFF));
		add_row(CMD_DELETE, 7'd127, 0, 0, 1, mk(0, ST_RANGE, 4, 32'sh7FFF_FFFF));
		add_row(CMD_DELETE, 0, 0, 0, 0, none);
		add_row(CMD_QUERY, 0, -100, 0, 0, none);
		add_row(CMD_CLEAR, 0, 0, 0, 1, mk(0, ST_OK, 0, 0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < n_rows; i++)
			send(rows[i].c, rows[i].idx, rows[i].t, rows[i].o, rows[i].typed, rows[i].res);

		for (int n = 0; n < 860; n++) begin
			r = $urandom_range(99);
			if (n % 250 == 120) begin
				// fill to capacity and beyond so that the full status appears
				send(CMD_CLEAR, 0, 0, 0, 0, none);
				for (k = 0; k < MAX_KEYS + 3; k++)
					send(CMD_INSERT, 7'(model_n), $urandom | 32'h8000_0000, $urandom, 0, none);
			end else if (r < 32 && model_n < MAX_KEYS) begin
				ix = $urandom_range(0, model_n);
				send(CMD_INSERT, 7'(ix), $urandom_range(1) ? ($urandom | 32'h8000_0000)
					: gap_time(ix, ix), $urandom, 0, none);
			end else if (r < 58) begin
				send(CMD_QUERY, 7'($urandom), pick_time(), $urandom, 0, none);
			end else if (r < 68) begin
				ix = $urandom_range(0, model_n);
				send(CMD_DELETE, 7'(ix), $urandom, $urandom, 0, none);
			end else if (r < 82) begin
				ix = model_n ? $urandom_range(0, model_n) : 0;
				send(CMD_CHECK, 7'(ix), gap_time(ix, ix + 1), $urandom, 0, none);
			end else if (r < 84) begin
				send(CMD_CLEAR, 7'($urandom), $urandom, $urandom, 0, none);
			end else begin
				// noise: any code, any index, any time
				c = 3'($urandom);
				send(c, 7'($urandom), $urandom, $urandom, 0, none);
			end
		end

		start <= 1'b0;
		while (exp_rd != exp_wr) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/kti_pkg.sv
rtl/core/kti_ram.sv
rtl/core/kti_datapath.sv
rtl/core/kti_ctrl.sv
rtl/core/keyframe_track_interpolator_core.sv
sim/tb_keyframe_track_interpolator_core.sv
